/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion shorthands for clk / rst based blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* rtl/lpfe_pkg.sv */
// ----------------------------------------------------------------------------
// lpfe_pkg
// Types and constants for the LED panel frame buffer engine.
// ----------------------------------------------------------------------------
package lpfe_pkg;

  localparam int BPL_DEFAULT = 8;
  localparam int LINES       = 16;

  localparam logic [7:0] BYTE_DARK = 8'hFF;
  localparam logic [7:0] BYTE_LIT  = 8'h00;
  localparam logic [7:0] MSB_MASK  = 8'h80;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_GET    = 2'd1,
    OP_SCROLL = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef struct packed {
    op_t        operation;
    logic [5:0] x_pos;
    logic [3:0] y_pos;
    logic [2:0] first_byte;
    logic [2:0] last_byte;
    logic       lit;
  } req_t;

  typedef struct packed {
    logic pixel_lit;
    logic overflow_bit;
    logic error;
  } rsp_t;

  typedef enum logic [3:0] {
    S_INIT,   // power-up fill of the store
    S_IDLE,
    S_CLR,    // clear command fill
    S_RD,     // read byte at current column
    S_RDW,    // read data back: get / put / scroll start
    S_SRD,    // scroll: read right neighbor
    S_SWR,    // scroll: write shifted byte, advance
    S_SLAST,  // scroll: write last byte with inserted bit
    S_DONE    // hand result to output register
  } state_t;

endpackage

/* rtl/led_panel_framebuffer_engine.sv */
// ----------------------------------------------------------------------------
// led_panel_framebuffer_engine
// Active-low monochrome LED panel frame store with pixel put/get, line
// scroll and clear, one response per request.
// ----------------------------------------------------------------------------
// One request at a time through a single-port byte RAM (registered read)
// under a small sequencer; in_stall is high from accept until the response
// is loaded into the output register, which then waits on its own.
// A request flagged with an error goes straight to the response without
// touching the store. The RAM port reads or writes one byte per cycle.
// After reset the whole store is filled with dark pixels, during which no
// request is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module led_panel_framebuffer_engine
  import lpfe_pkg::*;
#(
  parameter int BYTES_PER_LINE = BPL_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_req,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out_rsp
);

  localparam int DEPTH = LINES * BYTES_PER_LINE;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = AW - 2;   // line index: group * bytes_per_line + column
  localparam int SW    = LW + 3;

  state_t state, state_next;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;

  logic [AW-1:0] cnt;
  logic [LW-1:0] line;
  logic [LW-1:0] line_inc;
  logic [1:0]    row;
  logic [2:0]    col;
  logic [2:0]    last;
  logic [2:0]    bitpos;
  logic          lit;
  op_t           op;
  logic [7:0]    cur;
  logic [7:0]    fill;
  rsp_t          res;

  logic          accept;
  logic          sweep_end;
  logic          col_err;
  logic          span_err;
  logic          req_err;
  logic [2:0]    col_sel;
  logic [SW-1:0] base;
  logic [SW-1:0] line_sum;
  logic [7:0]    pix_mask;
  logic          out_load;

  assign accept    = (state == S_IDLE) && in_valid;
  assign in_stall  = (state != S_IDLE);
  assign sweep_end = (cnt == AW'(DEPTH - 1));
  assign line_inc  = line + LW'(1);
  assign pix_mask  = MSB_MASK >> bitpos;
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);

  // request decode
  assign col_err  = ({3'b000, in_req.x_pos[5:3]} >= 6'(BYTES_PER_LINE));
  assign span_err = ({3'b000, in_req.last_byte} >= 6'(BYTES_PER_LINE)) ||
                    (in_req.first_byte > in_req.last_byte);
  always_comb begin
    unique case (in_req.operation)
      OP_PUT, OP_GET: req_err = col_err;
      OP_SCROLL:      req_err = span_err;
      default:        req_err = 1'b0;
    endcase
  end
  assign col_sel  = (in_req.operation == OP_SCROLL) ? in_req.first_byte
                                                    : in_req.x_pos[5:3];
  assign base     = SW'(in_req.y_pos[3:2]) * SW'(BYTES_PER_LINE);
  assign line_sum = base + SW'(col_sel);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:  if (sweep_end) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (in_req.operation == OP_CLEAR) state_next = S_CLR;
          else if (req_err)                 state_next = S_DONE;
          else                              state_next = S_RD;
        end
      end
      S_CLR:   if (sweep_end) state_next = S_DONE;
      S_RD:    state_next = S_RDW;
      S_RDW: begin
        if (op == OP_SCROLL) state_next = (col == last) ? S_SLAST : S_SRD;
        else                 state_next = S_DONE;
      end
      S_SRD:   state_next = S_SWR;
      S_SWR:   state_next = ((col + 3'd1) == last) ? S_SLAST : S_SRD;
      S_SLAST: state_next = S_DONE;
      S_DONE:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // RAM port control
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = {line, row};
    mem_wdata = cur;
    unique case (state)
      S_INIT, S_CLR: begin
        mem_we    = 1'b1;
        mem_addr  = cnt;
        mem_wdata = fill;
      end
      S_RDW: begin
        if (op == OP_PUT) begin
          mem_we    = 1'b1;
          mem_wdata = lit ? (rdata & ~pix_mask) : (rdata | pix_mask);
        end
      end
      S_SRD:   mem_addr = {line_inc, row};
      S_SWR: begin
        mem_we    = 1'b1;
        mem_wdata = {cur[6:0], rdata[7]};
      end
      S_SLAST: begin
        mem_we    = 1'b1;
        mem_wdata = {cur[6:0], ~lit};
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt   <= '0;
      fill  <= BYTE_DARK;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt  <= '0;
        fill <= in_req.lit ? BYTE_LIT : BYTE_DARK;
      end else if (state == S_INIT || state == S_CLR) begin
        cnt <= cnt + AW'(1);
      end
    end
  end

  // per-request working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op        <= in_req.operation;
      line      <= line_sum[LW-1:0];
      row       <= in_req.y_pos[1:0];
      col       <= in_req.first_byte;
      last      <= in_req.last_byte;
      bitpos    <= in_req.x_pos[2:0];
      lit       <= in_req.lit;
      res       <= '{pixel_lit: 1'b0, overflow_bit: 1'b0, error: req_err};
    end else begin
      unique case (state)
        S_RDW: begin
          if (op == OP_GET) res.pixel_lit <= ~|(rdata & pix_mask);
          if (op == OP_SCROLL) begin
            cur              <= rdata;
            res.overflow_bit <= rdata[7];
          end
        end
        S_SWR: begin
          cur  <= rdata;
          line <= line_inc;
          col  <= col + 3'd1;
        end
        default: cur <= cur;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_rsp <= res;
  end

  `ASSERT_NEVER(a_err_clean, out_valid && out_rsp.error && (out_rsp.pixel_lit || out_rsp.overflow_bit), "error response carries data")
  `ASSERT_NEVER(a_one_result, out_valid && out_rsp.pixel_lit && out_rsp.overflow_bit, "get and scroll results both set")
  `ASSERT_CLK(a_accept_busy, (in_valid && !in_stall) |=> (state != S_IDLE), "request accepted but sequencer idle")
  `ASSERT_NEVER(a_idle_write, mem_we && (state == S_IDLE || state == S_DONE || state == S_RD), "store written outside a write step")

endmodule
